// ===== hw/rtl/lqba_pkg.sv =====
// Shared constants and controller/datapath types for the burst arbiter.
`default_nettype none

package lqba_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 10;
    localparam int BURST_W         = 5;
    localparam int MAX_BURST       = 16;
    localparam int BURST_RESET     = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_SERVE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic push;        // input transaction taken this edge
        logic start;       // latch served queue and burst length
        logic rd;          // read head of served queue and pop it
        logic load;        // load output register with popped id
        logic load_empty;  // load output register with the no-service result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic any_waiting;
        logic out_free;
        logic last_one;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/lqba_if.sv =====
// Handshake channel interfaces: arrival input, result output, configuration write.
`default_nettype none

interface lqba_in_if #(
    parameter int ID_WIDTH = lqba_pkg::ID_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic                arrival_valid;
    logic [ID_WIDTH-1:0] vehicle_id;
    logic                direction;

    modport source (output valid, arrival_valid, vehicle_id, direction, input ready);
    modport sink   (input valid, arrival_valid, vehicle_id, direction, output ready);
endinterface

interface lqba_out_if #(
    parameter int ID_WIDTH = lqba_pkg::ID_WIDTH_DEF,
    parameter int CNT_W    = $clog2(lqba_pkg::QUEUE_DEPTH_DEF + 1)
);
    logic                valid;
    logic                ready;
    logic                crossed;
    logic [ID_WIDTH-1:0] crossing_id;
    logic                crossing_direction;
    logic                last;
    logic                arrival_dropped;
    logic [CNT_W-1:0]    north_waiting;
    logic [CNT_W-1:0]    south_waiting;

    modport source (output valid, crossed, crossing_id, crossing_direction, last,
                    arrival_dropped, north_waiting, south_waiting, input ready);
    modport sink   (input valid, crossed, crossing_id, crossing_direction, last,
                    arrival_dropped, north_waiting, south_waiting, output ready);
endinterface

interface lqba_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lqba_pkg::BURST_W-1:0] burst_limit;

    modport source (output valid, burst_limit, input ready);
    modport sink   (input valid, burst_limit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lqba_queue.sv =====
// Circular FIFO with a registered-read memory, head/tail pointers and fill count.
`default_nettype none

module lqba_queue #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 10,
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_rd_data,
    output logic      [CNT_W-1:0]  o_count,
    output logic                   o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              push_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign push_ok = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push_ok) begin
            n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        end
        unique case ({push_ok, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

`default_nettype wire

// ===== hw/rtl/lqba_datapath.sv =====
// Datapath: two queues, burst limit register, served-queue choice and output register.
`default_nettype none

module lqba_datapath #(
    parameter int QUEUE_DEPTH = lqba_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = lqba_pkg::ID_WIDTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lqba_pkg::t_cmd                i_cmd,
    output lqba_pkg::t_sts                     o_sts,
    input  wire logic                          i_arrival_valid,
    input  wire logic [ID_WIDTH-1:0]           i_vehicle_id,
    input  wire logic                          i_direction,
    input  wire logic                          i_cfg_valid,
    input  wire logic [lqba_pkg::BURST_W-1:0]  i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_crossed,
    output logic      [ID_WIDTH-1:0]           o_crossing_id,
    output logic                               o_crossing_direction,
    output logic                               o_last,
    output logic                               o_arrival_dropped,
    output logic      [CNT_W-1:0]              o_north_waiting,
    output logic      [CNT_W-1:0]              o_south_waiting
);
    import lqba_pkg::*;

    localparam int CMP_W = (CNT_W > BURST_W) ? CNT_W : BURST_W;

    logic [ID_WIDTH-1:0] n_rd_data, s_rd_data;
    logic [CNT_W-1:0]    n_cnt, s_cnt;
    logic                n_full, s_full;
    logic                push_n, push_s, pop_n, pop_s;

    logic [BURST_W-1:0]  r_limit;
    logic [BURST_W-1:0]  eff_limit;
    logic [BURST_W-1:0]  r_rem;
    logic [BURST_W-1:0]  rem_init;
    logic                r_dir;
    logic                r_dropped;
    logic                pick_dir;
    logic                rd_dir;
    logic [CMP_W-1:0]    cnt_x, lim_x, min_x;

    logic                r_out_valid;
    logic                r_crossed;
    logic [ID_WIDTH-1:0] r_id;
    logic                r_out_dir;
    logic                r_last;
    logic                r_out_dropped;
    logic [CNT_W-1:0]    r_nw, r_sw;

    // north wins only when strictly longer; nonempty ties and north-empty go south
    assign pick_dir = (n_cnt > s_cnt) ? 1'b0 : (s_cnt != '0);
    assign rd_dir   = i_cmd.start ? pick_dir : r_dir;

    assign push_n = i_cmd.push && i_arrival_valid && !i_direction;
    assign push_s = i_cmd.push && i_arrival_valid &&  i_direction;
    assign pop_n  = i_cmd.rd && !rd_dir;
    assign pop_s  = i_cmd.rd &&  rd_dir;

    lqba_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(ID_WIDTH), .CNT_W(CNT_W)) u_north (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_n),
        .i_push_data (i_vehicle_id),
        .i_pop       (pop_n),
        .o_rd_data   (n_rd_data),
        .o_count     (n_cnt),
        .o_full      (n_full)
    );

    lqba_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(ID_WIDTH), .CNT_W(CNT_W)) u_south (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_s),
        .i_push_data (i_vehicle_id),
        .i_pop       (pop_s),
        .o_rd_data   (s_rd_data),
        .o_count     (s_cnt),
        .o_full      (s_full)
    );

    // zero means one, anything past the cap saturates
    always_comb begin
        if (r_limit == '0) begin
            eff_limit = BURST_W'(1);
        end else if (r_limit > BURST_W'(MAX_BURST)) begin
            eff_limit = BURST_W'(MAX_BURST);
        end else begin
            eff_limit = r_limit;
        end
        cnt_x    = CMP_W'(pick_dir ? s_cnt : n_cnt);
        lim_x    = CMP_W'(eff_limit);
        min_x    = (cnt_x < lim_x) ? cnt_x : lim_x;
        rem_init = min_x[BURST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= BURST_W'(BURST_RESET);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_dropped <= i_arrival_valid && (i_direction ? s_full : n_full);
        end
        if (i_cmd.start) begin
            r_dir <= pick_dir;
            r_rem <= rem_init;
        end else if (i_cmd.load) begin
            r_rem <= r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load || i_cmd.load_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // counts already reflect this result's pop; the next pop lands on this edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_crossed     <= 1'b1;
            r_id          <= r_dir ? s_rd_data : n_rd_data;
            r_out_dir     <= r_dir;
            r_last        <= (r_rem == BURST_W'(1));
            r_out_dropped <= r_dropped;
            r_nw          <= n_cnt;
            r_sw          <= s_cnt;
        end else if (i_cmd.load_empty) begin
            r_crossed     <= 1'b0;
            r_id          <= '0;
            r_out_dir     <= 1'b0;
            r_last        <= 1'b1;
            r_out_dropped <= r_dropped;
            r_nw          <= n_cnt;
            r_sw          <= s_cnt;
        end
    end

    always_comb begin
        o_sts.any_waiting = (n_cnt != '0) || (s_cnt != '0);
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.last_one    = (r_rem == BURST_W'(1));
    end

    assign o_out_valid          = r_out_valid;
    assign o_crossed            = r_crossed;
    assign o_crossing_id        = r_id;
    assign o_crossing_direction = r_out_dir;
    assign o_last               = r_last;
    assign o_arrival_dropped    = r_out_dropped;
    assign o_north_waiting      = r_nw;
    assign o_south_waiting      = r_sw;

endmodule

`default_nettype wire

// ===== hw/rtl/lqba_ctrl.sv =====
// Controller state machine: takes a step, picks a queue, sequences the burst.
`default_nettype none

module lqba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lqba_pkg::t_sts i_sts,
    output lqba_pkg::t_cmd      o_cmd
);
    import lqba_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PICK;
            end
            ST_PICK: begin
                if (i_sts.any_waiting) begin
                    n_state = ST_SERVE;
                end else if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SERVE: begin
                if (i_sts.out_free && i_sts.last_one) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.push = i_in_valid;
            end
            ST_PICK: begin
                if (i_sts.any_waiting) begin
                    o_cmd.start = 1'b1;
                    o_cmd.rd    = 1'b1;
                end else begin
                    o_cmd.load_empty = i_sts.out_free;
                end
            end
            ST_SERVE: begin
                // read of the next id overlaps the load of this one
                o_cmd.load = i_sts.out_free;
                o_cmd.rd   = i_sts.out_free && !i_sts.last_one;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/two_fifo_longest_queue_burst_arbiter_top.sv =====
// Top level: longest-queue-first two-FIFO arbiter with a per-step burst limit.
//
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          arrival_valid, vehicle_id, direction
//  o_out    out  valid/ready          crossed, crossing_id, crossing_direction, last,
//                                     arrival_dropped, north_waiting, south_waiting
//  i_cfg    in   valid/ready (ready=1) burst_limit
//
// A step pushes the input, then picks the queue and starts the head read, then loads
// one result each time the output is free; with both queues empty it gives the
// no-service result. Each queue memory has a single registered read port.
// Reset clears the queue pointers and counts and sets burst_limit to 10; stores are
// not cleared. A stalled output holds the burst; the input is taken only between steps,
// but a step may be taken while the previous final result still waits in o_out.
`default_nettype none

module two_fifo_longest_queue_burst_arbiter_top #(
    parameter int QUEUE_DEPTH = lqba_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = lqba_pkg::ID_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lqba_in_if.sink     i_in,
    lqba_out_if.source  o_out,
    lqba_cfg_if.sink    i_cfg
);
    import lqba_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    lqba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lqba_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_arrival_valid      (i_in.arrival_valid),
        .i_vehicle_id         (i_in.vehicle_id),
        .i_direction          (i_in.direction),
        .i_cfg_valid          (i_cfg.valid),
        .i_cfg_data           (i_cfg.burst_limit),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_crossed            (o_out.crossed),
        .o_crossing_id        (o_out.crossing_id),
        .o_crossing_direction (o_out.crossing_direction),
        .o_last               (o_out.last),
        .o_arrival_dropped    (o_out.arrival_dropped),
        .o_north_waiting      (o_out.north_waiting),
        .o_south_waiting      (o_out.south_waiting)
    );

`ifndef SYNTH
    a_step_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken twice in a row");

    a_nonlast_is_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> o_out.crossed)
        else $error("non-final result without a served id");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.crossed) |->
            (o_out.crossing_id == '0 && o_out.north_waiting == '0 &&
             o_out.south_waiting == '0))
        else $error("no-service result with queued items or nonzero id");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.north_waiting <= CNT_W'(QUEUE_DEPTH) &&
                         o_out.south_waiting <= CNT_W'(QUEUE_DEPTH)))
        else $error("waiting count beyond queue depth");
`endif

endmodule

`default_nettype wire
